FILE: hdl/bbe_pkg.sv
// Shared types, sizes and register indexes of the 3x3 edge-normalized box blur.
package bbe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int ROW_W  = OROW_W + 2;
  localparam int WDIM_W = COL_W + 1;
  localparam int HDIM_W = OROW_W + 1;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam int OPQ_DEPTH  = 4;
  localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
  localparam int RESQ_DEPTH = 8;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } res_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // One stream step handed from front to back.
  typedef struct packed {
    logic             real_px;
    pixel_t           pix;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic             last;
  } op_t;

  function automatic logic [WDIM_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    if (v == '0) return WDIM_W'(1);
    if (int'(v) > MAX_WIDTH) return WDIM_W'(MAX_WIDTH);
    return WDIM_W'(v);
  endfunction

  function automatic logic [HDIM_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    if (v == '0) return HDIM_W'(1);
    if (int'(v) > MAX_HEIGHT) return HDIM_W'(MAX_HEIGHT);
    return HDIM_W'(v);
  endfunction

endpackage

FILE: hdl/bbe_front.sv
// Front end: frame registers, stream position tracking and item classification.
module bbe_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbe_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          push_i,
  input  bbe_pkg::in_t                  in_data_i,
  output logic                          full_o,
  input  logic                          q_full_i,
  output logic                          op_push_o,
  output bbe_pkg::op_t                  op_o
);
  import bbe_pkg::*;

  logic [WDIM_W-1:0] w_q;
  logic [HDIM_W-1:0] h_q;
  logic [COL_W-1:0]  col_q, col_d, ocol_q, ocol_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [OROW_W-1:0] orow_q, orow_d;
  logic              pend_q, pend_d;

  logic accept, in_frame, adv, adv_real, early, emit;
  logic col_last, ocol_last, orow_last, last;

  assign full_o   = pend_q | q_full_i;
  assign accept   = push_i & ~full_o;
  assign in_frame = row_q < ROW_W'(h_q);

  always_comb begin
    early     = (row_q == '0) || (row_q == ROW_W'(1) && col_q == '0);
    emit      = ~early;
    col_last  = {1'b0, col_q} == (w_q - WDIM_W'(1));
    ocol_last = {1'b0, ocol_q} == (w_q - WDIM_W'(1));
    orow_last = {1'b0, orow_q} == (h_q - HDIM_W'(1));
    last      = emit & ocol_last & orow_last;

    if (pend_q) begin
      adv      = ~q_full_i;
      adv_real = 1'b0;
    end else begin
      adv      = accept & (~in_frame | ~in_data_i.kind);
      adv_real = in_frame;
    end

    op_o.real_px  = adv_real;
    op_o.pix      = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    op_o.col      = col_q;
    op_o.emit     = emit;
    op_o.top_ok   = orow_q != '0;
    op_o.bot_ok   = ~orow_last;
    op_o.left_ok  = ocol_q != '0;
    op_o.right_ok = ~ocol_last;
    op_o.last     = last;
    op_push_o     = adv;

    col_d  = col_q;
    row_d  = row_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    pend_d = pend_q;
    if (adv) begin
      // a flush step that yields nothing is followed by one that does
      pend_d = ~adv_real & ~emit;
      if (col_last) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
      if (emit) begin
        if (ocol_last) begin
          ocol_d = '0;
          orow_d = orow_q + OROW_W'(1);
        end else begin
          ocol_d = ocol_q + COL_W'(1);
        end
      end
      if (last) begin
        col_d  = '0;
        row_d  = '0;
        ocol_d = '0;
        orow_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= clamp_width(CFG_W'(640));
      h_q    <= clamp_height(CFG_W'(480));
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      pend_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == CFG_FRAME_WIDTH || cfg_idx_i == CFG_FRAME_HEIGHT)) begin
      if (cfg_idx_i == CFG_FRAME_WIDTH) begin
        w_q <= clamp_width(cfg_data_i);
      end else begin
        h_q <= clamp_height(cfg_data_i);
      end
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      pend_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      pend_q <= pend_d;
    end
  end

endmodule

FILE: hdl/bbe_op_queue.sv
// Short queue of stream steps between front and back.
module bbe_op_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  bbe_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output bbe_pkg::op_t op_o
);
  import bbe_pkg::*;

  op_t                mem_q [OPQ_DEPTH];
  logic [OPQ_AW-1:0]  wr_q, rd_q;
  logic [OPQ_AW:0]    cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == (OPQ_AW+1)'(OPQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + OPQ_AW'(1);
      if (do_pop)  rd_q <= rd_q + OPQ_AW'(1);
      cnt_q <= cnt_q + (OPQ_AW+1)'(do_push) - (OPQ_AW+1)'(do_pop);
    end
  end

endmodule

FILE: hdl/bbe_back.sv
// Back end: line stores, 3x3 window, neighborhood means and result queue.
module bbe_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_empty_i,
  input  bbe_pkg::op_t q_op_i,
  output logic         q_pop_o,
  output logic         empty_o,
  input  logic         pop_i,
  output bbe_pkg::res_t res_o
);
  import bbe_pkg::*;

  pixel_t upper_mem [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];
  pixel_t rd_up_q, rd_mid_q;

  // stage A: op with line data
  logic   a_v_q, a_fwd_q;
  op_t    a_op_q;
  pixel_t last_mid_q, last_pix_q;
  pixel_t top_e, mid_e, bot_e;

  // stage B: window
  logic   b_v_q;
  op_t    b_op_q;
  pixel_t win_q [9];

  // stage C: sums
  logic        c_v_q, c_last_q;
  logic [11:0] c_sum_q [3];
  logic [3:0]  c_cnt_q;

  logic [11:0] sum_d [3];
  logic [3:0]  cnt_d;
  logic [1:0]  rc, cc;
  logic [8:0]  tap_ok;

  res_t                res_mem_q [RESQ_DEPTH];
  logic [RESQ_AW-1:0]  res_wr_q, res_rd_q;
  logic [RESQ_AW:0]    res_cnt_q, reserve;
  logic                res_push, res_pop;

  function automatic logic [7:0] div_count(input logic [11:0] sum, input logic [3:0] cnt);
    logic [11:0] m;
    logic [11:0] x;
    logic [11:0] k;
    logic [3:0]  sh;
    logic [23:0] prod;
    m  = sum + 12'(cnt >> 1);
    x  = m;
    k  = 12'd1;
    sh = 4'd0;
    unique case (cnt)
      4'd2: sh = 4'd1;
      4'd4: sh = 4'd2;
      4'd3: begin
        k  = 12'd2731;
        sh = 4'd13;
      end
      4'd6: begin
        x  = m >> 1;
        k  = 12'd2731;
        sh = 4'd13;
      end
      4'd9: begin
        k  = 12'd3641;
        sh = 4'd15;
      end
      default: begin
      end
    endcase
    prod = 24'(x) * 24'(k);
    return 8'(prod >> sh);
  endfunction

  // hold back ops unless every in-flight result has a slot
  assign reserve = res_cnt_q + (RESQ_AW+1)'(a_v_q) + (RESQ_AW+1)'(b_v_q)
                 + (RESQ_AW+1)'(c_v_q);
  assign q_pop_o = ~q_empty_i & (reserve < (RESQ_AW+1)'(RESQ_DEPTH));

  // one-pixel-wide frames hit the same column on consecutive steps
  always_comb begin
    top_e = a_fwd_q ? last_mid_q : rd_up_q;
    mid_e = a_fwd_q ? last_pix_q : rd_mid_q;
    bot_e = a_op_q.real_px ? a_op_q.pix : '0;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_up_q  <= upper_mem[q_op_i.col];
      rd_mid_q <= middle_mem[q_op_i.col];
    end
    if (a_v_q && a_op_q.real_px) begin
      upper_mem[a_op_q.col]  <= mid_e;
      middle_mem[a_op_q.col] <= a_op_q.pix;
    end
  end

  always_comb begin
    rc = 2'd1 + 2'(b_op_q.top_ok) + 2'(b_op_q.bot_ok);
    cc = 2'd1 + 2'(b_op_q.left_ok) + 2'(b_op_q.right_ok);
    cnt_d = 4'(rc) * 4'(cc);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap_ok[r*3+c] = (r == 0 ? b_op_q.top_ok : (r == 2 ? b_op_q.bot_ok : 1'b1))
                      & (c == 0 ? b_op_q.left_ok : (c == 2 ? b_op_q.right_ok : 1'b1));
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
    end
    for (int t = 0; t < 9; t++) begin
      if (tap_ok[t]) begin
        sum_d[0] = sum_d[0] + 12'(win_q[t].r);
        sum_d[1] = sum_d[1] + 12'(win_q[t].g);
        sum_d[2] = sum_d[2] + 12'(win_q[t].b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_op_q  <= q_op_i;
      a_fwd_q <= a_v_q & a_op_q.real_px & (a_op_q.col == q_op_i.col);
    end
    if (a_v_q) begin
      last_mid_q <= mid_e;
      last_pix_q <= a_op_q.pix;
      b_op_q     <= a_op_q;
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= top_e;
      win_q[5] <= mid_e;
      win_q[8] <= bot_e;
    end
    if (b_v_q) begin
      c_sum_q  <= sum_d;
      c_cnt_q  <= cnt_d;
      c_last_q <= b_op_q.last;
    end
    if (res_push) begin
      res_mem_q[res_wr_q] <= '{red_out:   div_count(c_sum_q[0], c_cnt_q),
                               green_out: div_count(c_sum_q[1], c_cnt_q),
                               blue_out:  div_count(c_sum_q[2], c_cnt_q),
                               frame_end: c_last_q};
    end
  end

  assign res_push = c_v_q;
  assign empty_o  = res_cnt_q == '0;
  assign res_pop  = pop_i & ~empty_o;
  assign res_o    = res_mem_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      a_v_q <= q_pop_o;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q & b_op_q.emit;
      if (res_push) res_wr_q <= res_wr_q + RESQ_AW'(1);
      if (res_pop)  res_rd_q <= res_rd_q + RESQ_AW'(1);
      res_cnt_q <= res_cnt_q + (RESQ_AW+1)'(res_push) - (RESQ_AW+1)'(res_pop);
    end
  end

endmodule

FILE: hdl/box_blur_3x3_edge_normalized_core.sv
// 3x3 box blur of an RGB raster stream with means over in-frame neighbors only.
// Pixels enter in raster order, one per clock while full is low; each result is the
// rounded-half-up mean of each channel over the neighbors inside the frame (9, 6 on
// an edge, 4 at a corner). A result becomes ready once the pixel one row plus one
// column later has been transferred, then passes the three back-end stages (line
// read, window shift, sums) and is divided as it enters the result queue. Throughput
// is one item per clock while full is low. After the frame, drain items flush the
// pending results one per item; frame_end marks the frame's last result. For a
// frame one pixel high the first drain adds a stream step that yields no result.
// Drains before the frame is complete are dropped; pixels after it act as drains.
// Writing frame_width or frame_height restarts the frame; write only when idle.
module box_blur_3x3_edge_normalized_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbe_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          push,
  input  bbe_pkg::in_t                  in_data_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output bbe_pkg::res_t                 res_data_o
);
  import bbe_pkg::*;

  logic op_push, q_full, q_pop, q_empty;
  op_t  op_in, op_head;

  // classify and position each transfer
  bbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .q_full_i   (q_full),
    .op_push_o  (op_push),
    .op_o       (op_in)
  );

  bbe_op_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (op_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (op_head)
  );

  // line stores, window, averaging, result queue
  bbe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_op_i    (op_head),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (res_data_o)
  );

endmodule

FILE: hdl/bbe_checker.sv
// Port-level checks of the box blur core and their binding.
module bbe_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input bbe_pkg::res_t res_data_o
);
  import bbe_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result withdrawn");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(res_data_o))
    else $error("waiting result changed");

  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full raised without an input transfer");

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> empty && !full)
    else $error("not idle after reset");

endmodule

bind box_blur_3x3_edge_normalized_core bbe_checker u_bbe_checker (.*);

FILE: sim/tb_box_blur_3x3_edge_normalized_core.sv
// Self-checking testbench for the 3x3 edge-normalized box blur core.
module tb_box_blur_3x3_edge_normalized_core;
  import bbe_pkg::*;

  localparam int IDLE_LIMIT = 5000;  // cycles without any transfer before giving up
  localparam int SETTLE     = 24;    // quiet cycles after the last result
  localparam int LONG_HOLD  = 400;   // one long receiver stall
  localparam int HOLD_AT    = 20;    // result count that triggers it

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  in_t                  in_data = '0;
  logic                 full;
  logic                 empty;
  logic                 pop = 1'b0;
  res_t                 res_data;

  box_blur_3x3_edge_normalized_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .in_data_i  (in_data),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .res_data_o (res_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Blur predictor: own copy of the line stores, window and stream position.
  // ---------------------------------------------------------------------------
  logic [23:0] upper_ln [MAX_WIDTH];
  logic [23:0] middle_ln[MAX_WIDTH];
  logic [23:0] win[9];
  int unsigned fr_w, fr_h, px_col, px_row, next_out;

  res_t blur_q[$];     // blurred pixels still owed by the core
  in_t  pending_q[$];  // stimulus not yet transferred
  int   errors = 0;

  function automatic int unsigned size_of(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return v;
  endfunction

  function automatic logic [7:0] mean_of(int unsigned sh, int unsigned r, int unsigned c);
    int unsigned sum, cnt, nr, nc;
    sum = 0;
    cnt = 0;
    for (int unsigned wr = 0; wr < 3; wr++) begin
      for (int unsigned wc = 0; wc < 3; wc++) begin
        nr = r + wr - 1;  // wraps to a huge value for row -1
        nc = c + wc - 1;
        if (nr < fr_h && nc < fr_w) begin
          sum += (win[wr*3+wc] >> sh) & 8'hFF;
          cnt++;
        end
      end
    end
    return 8'((2*sum + cnt) / (2*cnt));  // round half up
  endfunction

  // One stream position; a virtual one (real_px = 0) fills the bottom tap with zero.
  function automatic bit blur_advance(bit real_px, logic [23:0] pix);
    int unsigned c, pos, total;
    logic [23:0] top, mid, bot;
    res_t r;
    c = px_col;
    top = '0;
    mid = '0;
    bot = '0;
    if (c < MAX_WIDTH) begin
      top = upper_ln[c];
      mid = middle_ln[c];
      if (real_px) begin
        bot = pix;
        upper_ln[c] = mid;
        middle_ln[c] = pix;
      end
    end
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bot;
    pos = px_row * fr_w + px_col;
    px_col++;
    if (px_col >= fr_w) begin
      px_col = 0;
      px_row++;
    end
    total = fr_w * fr_h;
    if (pos < fr_w + 1 || next_out >= total) return 1'b0;
    r.red_out   = mean_of(16, next_out / fr_w, next_out % fr_w);
    r.green_out = mean_of(8,  next_out / fr_w, next_out % fr_w);
    r.blue_out  = mean_of(0,  next_out / fr_w, next_out % fr_w);
    next_out++;
    r.frame_end = (next_out >= total);
    if (r.frame_end) begin
      px_col = 0;
      px_row = 0;
      next_out = 0;
    end
    blur_q.push_back(r);
    return 1'b1;
  endfunction

  function automatic void blur_accept(in_t it);
    if (px_row < fr_h) begin
      if (!it.kind) void'(blur_advance(1'b1, {it.red_in, it.green_in, it.blue_in}));
    end else begin
      // frame complete: the item flushes exactly one pending result
      while (px_row >= fr_h) begin
        if (blur_advance(1'b0, '0)) break;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: push/data change at the falling edge, transfers counted at the rising.
  // ---------------------------------------------------------------------------
  int  tx_wait = 0, rx_wait = 0, res_cnt = 0, idle_cyc = 0;
  bit  tx_fast = 1'b0, rx_fast = 1'b0, held = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        blur_accept(pending_q.pop_front());
        tx_wait <= tx_fast ? 0 : $urandom_range(0, 17);
      end else if (tx_wait > 0) begin
        tx_wait <= tx_wait - 1;
      end
    end
  end

  always @(negedge clk_i) begin
    push    <= rst_ni && pending_q.size() > 0 && tx_wait == 0;
    in_data <= pending_q.size() > 0 ? pending_q[0] : '0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each transfer against the oldest expected blur result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (blur_q.size() == 0) begin
          $error("result with nothing expected: %h", res_data);
          errors++;
        end else begin
          e = blur_q.pop_front();
          if (res_data.red_out !== e.red_out) begin
            $error("red_out exp %0d got %0d", e.red_out, res_data.red_out);
            errors++;
          end
          if (res_data.green_out !== e.green_out) begin
            $error("green_out exp %0d got %0d", e.green_out, res_data.green_out);
            errors++;
          end
          if (res_data.blue_out !== e.blue_out) begin
            $error("blue_out exp %0d got %0d", e.blue_out, res_data.blue_out);
            errors++;
          end
          if (res_data.frame_end !== e.frame_end) begin
            $error("frame_end exp %0d got %0d", e.frame_end, res_data.frame_end);
            errors++;
          end
        end
        res_cnt <= res_cnt + 1;
        // one long stall while the sender keeps offering, so the core backs up
        if (res_cnt == HOLD_AT && !held) begin
          rx_wait <= LONG_HOLD;
          held <= 1'b1;
        end else begin
          rx_wait <= rx_fast ? 0 : $urandom_range(0, 17);
        end
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && rx_wait == 0;
  end

  // Watchdog on cycles with no transfer of any kind.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (pending_q.size() > 0 || blur_q.size() > 0 || push) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_FRAME_WIDTH) fr_w = size_of(val, MAX_WIDTH);
    else fr_h = size_of(val, MAX_HEIGHT);
    px_col = 0;
    px_row = 0;
    next_out = 0;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] color();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic in_t pixel_item(bit kind);
    in_t it;
    it.kind     = kind;
    it.red_in   = color();
    it.green_in = color();
    it.blue_in  = color();
    return it;
  endfunction

  // One well-formed frame with random colors; noise adds dropped drains early on.
  task automatic queue_frame(bit noise);
    int unsigned total, flush;
    total = fr_w * fr_h;
    flush = (fr_w + 1 < total) ? fr_w + 1 : total;
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 15) == 0) pending_q.push_back(pixel_item(1'b1));
      pending_q.push_back(pixel_item(1'b0));
    end
    // trailing pixels behave as drains
    for (int unsigned i = 0; i < flush; i++) begin
      pending_q.push_back(pixel_item(1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, bit noise);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    queue_frame(noise);
  endtask

  initial begin
    int sent;
    in_t it;
    fr_w = 640;
    fr_h = 480;
    px_col = 0;
    px_row = 0;
    next_out = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed 3x3 frame: color extremes, early drain dropped, mixed flush items.
    write_reg(CFG_FRAME_WIDTH, 11'd3);
    write_reg(CFG_FRAME_HEIGHT, 11'd3);
    it = '0;
    it.kind = 1'b1;
    pending_q.push_back(it);  // drain before frame is complete
    for (int i = 0; i < 9; i++) begin
      it.kind     = 1'b0;
      it.red_in   = (i % 2) ? 8'hFF : 8'h00;
      it.green_in = (i < 4) ? 8'hFF : 8'h01;
      it.blue_in  = 8'(i * 31);
      pending_q.push_back(it);
    end
    for (int i = 0; i < 4; i++) begin
      it.kind     = (i < 2);
      it.red_in   = 8'hFF;
      it.green_in = 8'hFF;
      it.blue_in  = 8'hFF;
      pending_q.push_back(it);  // drains, then pixels acting as drains
    end

    // Receiver stall lands in this frame; the sender runs flat out meanwhile.
    wait_idle();
    tx_fast = 1'b1;
    run_frame(11'd16, 11'd8, 1'b0);
    wait_idle();
    tx_fast = 1'b0;

    // Size extremes: zero acts as one, single rows and columns.
    run_frame(11'd0, 11'd1, 1'b0);
    run_frame(11'd1, 11'd5, 1'b1);
    run_frame(11'd5, 11'd1, 1'b1);
    run_frame(11'd2, 11'd2, 1'b0);
    run_frame(11'd3, 11'd0, 1'b0);

    // Random frames, some with no idling on either side.
    sent = 0;
    while (sent < 560) begin
      wait_idle();
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      write_reg(CFG_FRAME_WIDTH, 11'($urandom_range(1, 12)));
      write_reg(CFG_FRAME_HEIGHT, 11'($urandom_range(1, 8)));
      if ($urandom_range(0, 7) == 0) pending_q.push_back(pixel_item(1'b1));
      queue_frame(1'b1);
      sent += pending_q.size();
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
